### design/qrs_pkg.sv
// shared widths, types and helpers for the quadratic root solver
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int COEF_BITS     = 16;
  localparam int FRAC_BITS     = 16;
  localparam int OUT_BITS      = 40;
  localparam int PROD_BITS     = 2 * COEF_BITS;
  localparam int RAD_MAG_BITS  = 2 * COEF_BITS + 1;
  localparam int D_BITS        = RAD_MAG_BITS + 1;
  localparam int ROOT_BITS     = COEF_BITS + FRAC_BITS + 1;
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 2;
  localparam int NUM_BITS      = COEF_BITS + FRAC_BITS + 2;
  localparam int SNUM_BITS     = NUM_BITS + 1;
  localparam int DEN_BITS      = COEF_BITS + 1;
  localparam int EXT_BITS      = (SNUM_BITS > OUT_BITS) ? SNUM_BITS : OUT_BITS;
  localparam int LATENCY       = ROOT_BITS + NUM_BITS + 4;

  typedef enum logic [1:0] {
    KIND_COMPLEX = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_DOUBLE  = 2'd2,
    KIND_AZERO   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                        valid;
    kind_t                       kind;
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
  } sq_tag_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sq_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } dv_tag_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] num_p;
    logic [NUM_BITS-1:0] num_m;
    logic [DEN_BITS-1:0] rem_p;
    logic [DEN_BITS-1:0] rem_m;
    logic [DEN_BITS-1:0] den;
    logic                neg_p;
    logic                neg_m;
  } dv_t;

  // clamp to the signed output range
  function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [SNUM_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] x;
    logic signed [EXT_BITS-1:0] hi;
    logic signed [EXT_BITS-1:0] lo;
    x  = EXT_BITS'(v);
    hi = $signed({{(EXT_BITS - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}});
    lo = $signed({{(EXT_BITS - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}});
    if (x > hi) begin
      x = hi;
    end else if (x < lo) begin
      x = lo;
    end
    return x[OUT_BITS-1:0];
  endfunction

endpackage

### design/qrs_sqrt_cell.sv
// one root bit of the pipelined digit-by-digit square root
`timescale 1ns / 1ps
module qrs_sqrt_cell (
  input  logic             clk,
  input  logic             rst,
  input  qrs_pkg::sq_t     sq_i,
  input  qrs_pkg::sq_tag_t tag_i,
  output qrs_pkg::sq_t     sq_o,
  output qrs_pkg::sq_tag_t tag_o
);
  import qrs_pkg::*;

  logic [1:0]          pair;
  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic                ge;

  assign pair   = sq_i.rad[RAD_BITS-1 -: 2];
  assign rem_sh = {sq_i.rem[REM_BITS-3:0], pair};
  assign trial  = {sq_i.root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    sq_o.rad   <= sq_i.rad << 2;
    sq_o.rem   <= ge ? (rem_sh - trial) : rem_sh;
    sq_o.root  <= {sq_i.root[ROOT_BITS-2:0], ge};
    tag_o.kind <= tag_i.kind;
    tag_o.a    <= tag_i.a;
    tag_o.b    <= tag_i.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else begin
      tag_o.valid <= tag_i.valid;
    end
  end

endmodule

### design/qrs_div_cell.sv
// one quotient bit of both restoring dividers
`timescale 1ns / 1ps
module qrs_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  qrs_pkg::dv_t     dv_i,
  input  qrs_pkg::dv_tag_t tag_i,
  output qrs_pkg::dv_t     dv_o,
  output qrs_pkg::dv_tag_t tag_o
);
  import qrs_pkg::*;

  logic [DEN_BITS-1:0] sh_p;
  logic [DEN_BITS-1:0] sh_m;
  logic                ge_p;
  logic                ge_m;

  assign sh_p = {dv_i.rem_p[DEN_BITS-2:0], dv_i.num_p[NUM_BITS-1]};
  assign sh_m = {dv_i.rem_m[DEN_BITS-2:0], dv_i.num_m[NUM_BITS-1]};
  assign ge_p = (sh_p >= dv_i.den);
  assign ge_m = (sh_m >= dv_i.den);

  always_ff @(posedge clk) begin
    // dividend shifts out the top while quotient bits enter at the bottom
    dv_o.num_p <= {dv_i.num_p[NUM_BITS-2:0], ge_p};
    dv_o.num_m <= {dv_i.num_m[NUM_BITS-2:0], ge_m};
    dv_o.rem_p <= ge_p ? (sh_p - dv_i.den) : sh_p;
    dv_o.rem_m <= ge_m ? (sh_m - dv_i.den) : sh_m;
    dv_o.den   <= dv_i.den;
    dv_o.neg_p <= dv_i.neg_p;
    dv_o.neg_m <= dv_i.neg_m;
    tag_o.kind <= tag_i.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else begin
      tag_o.valid <= tag_i.valid;
    end
  end

endmodule

### design/quadratic_root_solver_unit.sv
// a taken request passes the input, product, divider input and output registers
// throughput: one request every cycle; busy stays low, the receiver cannot stall
// latency is set by the square root cell row (one per root bit) and the divider cell row
// (one per quotient bit)
// synchronous active-high reset clears all valid bits; no result follows reset by itself
`timescale 1ns / 1ps
module quadratic_root_solver_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_quad,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_lin,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_const,
  output logic                                 done,
  output logic [1:0]                           root_kind,
  output logic signed [qrs_pkg::OUT_BITS-1:0]  root_plus,
  output logic signed [qrs_pkg::OUT_BITS-1:0]  root_minus
);
  import qrs_pkg::*;

  // input register
  logic                        in_valid;
  logic signed [COEF_BITS-1:0] in_a;
  logic signed [COEF_BITS-1:0] in_b;
  logic signed [COEF_BITS-1:0] in_c;

  // product register
  logic                        pr_valid;
  logic signed [COEF_BITS-1:0] pr_a;
  logic signed [COEF_BITS-1:0] pr_b;
  logic signed [PROD_BITS-1:0] pr_bb;
  logic signed [PROD_BITS-1:0] pr_ac;

  logic signed [D_BITS-1:0] disc;
  kind_t                    kind;
  sq_t                      sq_chain  [ROOT_BITS+1];
  sq_tag_t                  sqt_chain [ROOT_BITS+1];
  dv_t                      dv_chain  [NUM_BITS+1];
  dv_tag_t                  dvt_chain [NUM_BITS+1];

  logic signed [SNUM_BITS-1:0] nb;
  logic signed [SNUM_BITS-1:0] s_ext;
  logic signed [SNUM_BITS-1:0] np;
  logic signed [SNUM_BITS-1:0] nm;
  logic [COEF_BITS-1:0]        a_mag;
  sq_tag_t                     sq_last;
  dv_t                         dv_last;
  logic signed [SNUM_BITS-1:0] q_p;
  logic signed [SNUM_BITS-1:0] q_m;
  logic                        real_root;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    in_a  <= coef_quad;
    in_b  <= coef_lin;
    in_c  <= coef_const;
    pr_a  <= in_a;
    pr_b  <= in_b;
    pr_bb <= in_b * in_b;
    pr_ac <= in_a * in_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      pr_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      pr_valid <= in_valid;
    end
  end

  // discriminant and classification feed the first root cell
  assign disc = D_BITS'(pr_bb) - (D_BITS'(pr_ac) <<< 2);

  always_comb begin
    priority if (pr_a == '0) begin
      kind = KIND_AZERO;
    end else if (disc[D_BITS-1]) begin
      kind = KIND_COMPLEX;
    end else if (disc == '0) begin
      kind = KIND_DOUBLE;
    end else begin
      kind = KIND_TWO;
    end
  end

  always_comb begin
    sq_chain[0].rad  = (kind == KIND_TWO) ?
                       (RAD_BITS'(disc[RAD_MAG_BITS-1:0]) << (2 * FRAC_BITS)) : '0;
    sq_chain[0].rem  = '0;
    sq_chain[0].root = '0;
    sqt_chain[0].valid = pr_valid;
    sqt_chain[0].kind  = kind;
    sqt_chain[0].a     = pr_a;
    sqt_chain[0].b     = pr_b;
  end

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .sq_i  (sq_chain[i]),
      .tag_i (sqt_chain[i]),
      .sq_o  (sq_chain[i+1]),
      .tag_o (sqt_chain[i+1])
    );
  end

  // numerators and divisor magnitude
  assign sq_last = sqt_chain[ROOT_BITS];
  assign nb      = -(SNUM_BITS'(sq_last.b) <<< FRAC_BITS);
  assign s_ext   = $signed(SNUM_BITS'(sq_chain[ROOT_BITS].root));
  assign np      = nb + s_ext;
  assign nm      = nb - s_ext;
  assign a_mag   = sq_last.a[COEF_BITS-1] ? COEF_BITS'(-sq_last.a) : COEF_BITS'(sq_last.a);

  always_ff @(posedge clk) begin
    dv_chain[0].num_p <= np[SNUM_BITS-1] ? NUM_BITS'(-np) : NUM_BITS'(np);
    dv_chain[0].num_m <= nm[SNUM_BITS-1] ? NUM_BITS'(-nm) : NUM_BITS'(nm);
    dv_chain[0].rem_p <= '0;
    dv_chain[0].rem_m <= '0;
    dv_chain[0].den   <= {a_mag, 1'b0};
    dv_chain[0].neg_p <= np[SNUM_BITS-1] ^ sq_last.a[COEF_BITS-1];
    dv_chain[0].neg_m <= nm[SNUM_BITS-1] ^ sq_last.a[COEF_BITS-1];
    dvt_chain[0].kind <= sq_last.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvt_chain[0].valid <= 1'b0;
    end else begin
      dvt_chain[0].valid <= sq_last.valid;
    end
  end

  for (genvar j = 0; j < NUM_BITS; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .dv_i  (dv_chain[j]),
      .tag_i (dvt_chain[j]),
      .dv_o  (dv_chain[j+1]),
      .tag_o (dvt_chain[j+1])
    );
  end

  // sign, clamp and output register
  assign dv_last   = dv_chain[NUM_BITS];
  assign q_p       = dv_last.neg_p ? -$signed(SNUM_BITS'(dv_last.num_p))
                                   : $signed(SNUM_BITS'(dv_last.num_p));
  assign q_m       = dv_last.neg_m ? -$signed(SNUM_BITS'(dv_last.num_m))
                                   : $signed(SNUM_BITS'(dv_last.num_m));
  assign real_root = (dvt_chain[NUM_BITS].kind == KIND_TWO) ||
                     (dvt_chain[NUM_BITS].kind == KIND_DOUBLE);

  always_ff @(posedge clk) begin
    root_kind  <= dvt_chain[NUM_BITS].kind;
    root_plus  <= real_root ? sat_out(q_p) : '0;
    root_minus <= real_root ? sat_out(q_m) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvt_chain[NUM_BITS].valid;
    end
  end

endmodule

### design/qrs_checker.sv
// port-level checks for the quadratic root solver and their binding
`timescale 1ns / 1ps
module qrs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic [1:0]                          root_kind,
  input logic signed [qrs_pkg::OUT_BITS-1:0] root_plus,
  input logic signed [qrs_pkg::OUT_BITS-1:0] root_minus
);
  import qrs_pkg::*;

  // every request comes back after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing after request");

  a_no_done_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  // no roots reported when they are not real
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    (done && (root_kind == KIND_COMPLEX || root_kind == KIND_AZERO))
      |-> (root_plus == '0 && root_minus == '0))
    else $error("nonzero root for non-real case");

  a_double_root: assert property (@(posedge clk) disable iff (rst)
    (done && root_kind == KIND_DOUBLE) |-> (root_plus == root_minus))
    else $error("double root with unequal values");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);

### test/quadratic_root_solver_unit_tb.sv
// testbench for the quadratic root solver: directed table plus random coefficient sets
`timescale 1ns / 1ps
module quadratic_root_solver_unit_tb;
  import qrs_pkg::*;

  localparam int N_RANDOM  = 900;
  localparam int MAX_CYCLES = 400000;

  typedef struct {
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] c;
    logic                        typed;
    kind_t                       kind;
    logic signed [OUT_BITS-1:0]  rp;
    logic signed [OUT_BITS-1:0]  rm;
  } coef_row_t;

  typedef struct {
    kind_t                      kind;
    logic signed [OUT_BITS-1:0] rp;
    logic signed [OUT_BITS-1:0] rm;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [COEF_BITS-1:0] coef_quad = '0;
  logic signed [COEF_BITS-1:0] coef_lin = '0;
  logic signed [COEF_BITS-1:0] coef_const = '0;
  logic done;
  logic [1:0] root_kind;
  logic signed [OUT_BITS-1:0] root_plus;
  logic signed [OUT_BITS-1:0] root_minus;

  roots_t pending_roots[$];
  int mismatches = 0;
  int results_seen = 0;
  int real_seen = 0;
  int cycles = 0;
  coef_row_t dir_rows[$];

  quadratic_root_solver_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_quad(coef_quad), .coef_lin(coef_lin), .coef_const(coef_const),
    .done(done), .root_kind(root_kind), .root_plus(root_plus), .root_minus(root_minus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(sqrt(d)) scaled by 2^FRAC_BITS, two radicand bits per step
  function automatic longint unsigned isqrt_fixed(input longint unsigned d);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned pair;
    rem = 0;
    root = 0;
    for (int i = 0; i < 32 + FRAC_BITS; i++) begin
      pair = (i < 32) ? ((d >> (62 - 2 * i)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] clamp40(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (OUT_BITS - 1)) - 1;
    lo = -(64'sd1 <<< (OUT_BITS - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_BITS-1:0];
  endfunction

  function automatic roots_t solve_roots(input logic signed [COEF_BITS-1:0] a,
                                         input logic signed [COEF_BITS-1:0] b,
                                         input logic signed [COEF_BITS-1:0] c);
    roots_t r;
    longint la;
    longint lb;
    longint disc;
    longint s;
    longint nb;
    la = a;
    lb = b;
    r.rp = '0;
    r.rm = '0;
    if (la == 0) begin
      r.kind = KIND_AZERO;
      return r;
    end
    disc = lb * lb - 4 * la * longint'(c);
    if (disc < 0) begin
      r.kind = KIND_COMPLEX;
      return r;
    end
    r.kind = (disc > 0) ? KIND_TWO : KIND_DOUBLE;
    s = longint'(isqrt_fixed(disc));
    nb = -lb * (64'sd1 <<< FRAC_BITS);
    r.rp = clamp40((nb + s) / (2 * la));
    r.rm = clamp40((nb - s) / (2 * la));
    return r;
  endfunction

  task automatic add_row(input int a, input int b, input int c, input logic typed,
                         input kind_t k, input longint rp, input longint rm);
    coef_row_t row;
    row.a = a[COEF_BITS-1:0];
    row.b = b[COEF_BITS-1:0];
    row.c = c[COEF_BITS-1:0];
    row.typed = typed;
    row.kind = k;
    row.rp = rp[OUT_BITS-1:0];
    row.rm = rm[OUT_BITS-1:0];
    dir_rows.push_back(row);
  endtask

  // start stays high between requests when no idle cycles are drawn
  task automatic send_request(input coef_row_t row);
    roots_t e;
    int idle;
    idle = $urandom_range(0, 18);
    repeat (idle) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    coef_quad <= row.a;
    coef_lin <= row.b;
    coef_const <= row.c;
    do @(posedge clk); while (busy);
    e = solve_roots(row.a, row.b, row.c);
    if (row.typed) begin
      e.kind = row.kind;
      e.rp = row.rp;
      e.rm = row.rm;
    end
    pending_roots.push_back(e);
  endtask

  // result monitor
  always @(posedge clk) begin
    roots_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (pending_roots.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result kind %0d", root_kind);
      end else begin
        e = pending_roots.pop_front();
        if (e.kind == KIND_TWO || e.kind == KIND_DOUBLE) real_seen <= real_seen + 1;
        if (root_kind != e.kind || root_plus != e.rp || root_minus != e.rm) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d plus %0d minus %0d, got kind %0d plus %0d minus %0d",
                     e.kind, e.rp, e.rm, root_kind, root_plus, root_minus);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    coef_row_t row;
    int sel;
    // a is zero, complex, double root and simple two-root rows typed in
    add_row(0, 5, 7, 1'b1, KIND_AZERO, 0, 0);
    add_row(0, -32768, 32767, 1'b1, KIND_AZERO, 0, 0);
    add_row(1, 0, 1, 1'b1, KIND_COMPLEX, 0, 0);
    add_row(32767, 0, 32767, 1'b1, KIND_COMPLEX, 0, 0);
    add_row(1, -2, 1, 1'b1, KIND_DOUBLE, 65536, 65536);
    add_row(1, 0, -1, 1'b1, KIND_TWO, 65536, -65536);
    add_row(1, 0, 0, 1'b1, KIND_DOUBLE, 0, 0);
    add_row(-1, 0, 1, 1'b1, KIND_TWO, -65536, 65536);
    // extremes and some small coefficient rows, checked by the predictor
    add_row(-32768, -32768, 32767, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(-32768, 32767, 32767, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(1, -32768, -32768, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(1, 32767, -32768, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(32767, -32768, -32768, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(-32768, -32768, -32768, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(-1, -32768, 32767, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(32767, 32767, 0, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(3, 7, 2, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(-7, 3, 5, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(-1, -1, -1, 1'b0, KIND_COMPLEX, 0, 0);
    add_row(2, -32768, 0, 1'b0, KIND_COMPLEX, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      row.typed = 1'b0;
      sel = $urandom_range(0, 9);
      row.a = COEF_BITS'($urandom());
      row.b = COEF_BITS'($urandom());
      row.c = COEF_BITS'($urandom());
      if (sel < 2) begin
        // small coefficients give many double and real cases
        row.a = COEF_BITS'($signed($urandom_range(0, 15)) - 8);
        row.b = COEF_BITS'($signed($urandom_range(0, 31)) - 16);
        row.c = COEF_BITS'($signed($urandom_range(0, 15)) - 8);
      end else if (sel == 2) begin
        row.a = '0;
      end else if (sel == 3) begin
        // perfect square: a*(x-r)^2 gives a double root
        row.a = COEF_BITS'($signed($urandom_range(0, 200)) - 100);
        row.b = COEF_BITS'(-2 * row.a * ($signed($urandom_range(0, 36)) - 18));
        row.c = (row.a == 0) ? 16'sd0 : COEF_BITS'((row.b * row.b) / (4 * row.a));
      end else if (sel < 6) begin
        // opposite signs of a and c force real roots
        row.c = (row.a[COEF_BITS-1]) ? {1'b0, row.c[COEF_BITS-2:0]}
                                    : {1'b1, row.c[COEF_BITS-2:0]};
      end
      send_request(row);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d coefficient sets, %0d results checked, %0d with real roots",
             dir_rows.size() + N_RANDOM, results_seen, real_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### quadratic_root_solver_unit.f
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver_unit.sv
design/qrs_checker.sv
test/quadratic_root_solver_unit_tb.sv
